// ----- design/stk_pkg.sv -----
// Shared types and constants for the stack with positional insert.
// Used by stk_cell and by stack_with_positional_insert; depends on nothing.
package stk_pkg;

    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_INSERT = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SEL_HOLD  = 2'd0,
        SEL_LOAD  = 2'd1,
        SEL_ABOVE = 2'd2,
        SEL_BELOW = 2'd3
    } cell_sel_t;

endpackage

// ----- design/stk_cell.sv -----
// One storage cell of the stack chain; holds the word at one depth from the top.
// Depends on stk_pkg for the word type and the cell select codes.
module stk_cell (
    input  logic              clk,
    input  stk_pkg::cell_sel_t sel,
    input  stk_pkg::word_t    value,
    input  stk_pkg::word_t    above,
    input  stk_pkg::word_t    below,
    output stk_pkg::word_t    word,
    output stk_pkg::word_t    word_next
);

    stk_pkg::word_t data_reg;
    stk_pkg::word_t data_next;

    always_comb
    begin
        case (sel)
            stk_pkg::SEL_HOLD:  data_next = data_reg;
            stk_pkg::SEL_LOAD:  data_next = value;
            stk_pkg::SEL_ABOVE: data_next = above;
            stk_pkg::SEL_BELOW: data_next = below;
            default:            data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign word      = data_reg;
    assign word_next = data_next;

endmodule

// ----- design/stack_with_positional_insert.sv -----
// Stack of signed words held in a chain of cells, cell 0 being the top of the stack.
// An accepted request beat gives its result beat in the next cycle.
// Throughput: one request beat per cycle; every op updates all affected cells in parallel.
// A stalled result blocks the input until the result beat is taken.
// Reset empties the stack and drops any pending result; cell words are not cleared.
// Depends on stk_pkg and stk_cell.
module stack_with_positional_insert #(
    parameter int DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   action,
    input  logic signed [31:0]           value,
    input  logic [$clog2(DEPTH+1)-1:0]   position,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   status,
    output logic [$clog2(DEPTH+1)-1:0]   count,
    output logic signed [31:0]           read_value
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic                 in_acc;
    stk_pkg::action_t     act;
    stk_pkg::status_t     status_c;
    logic                 push_ok;
    logic                 pop_ok;
    logic                 ins_ok;
    logic                 rd_ok;
    logic                 full;
    logic                 empty;
    logic [CW-1:0]        cnt_after;
    stk_pkg::word_t       rd_word;

    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    stk_pkg::status_t     status_reg;
    logic [CW-1:0]        cnt_out_reg;
    stk_pkg::word_t       rd_reg;

    stk_pkg::word_t       word_q [DEPTH];
    stk_pkg::word_t       word_d [DEPTH];
    stk_pkg::cell_sel_t   sel    [DEPTH];

    assign in_stall = out_valid_reg && out_stall;
    assign in_acc   = in_valid && !in_stall;
    assign act      = stk_pkg::action_t'(action);
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);

    always_comb
    begin
        status_c = stk_pkg::ST_DONE;
        push_ok  = 1'b0;
        pop_ok   = 1'b0;
        ins_ok   = 1'b0;
        rd_ok    = 1'b0;
        case (act)
            stk_pkg::ACT_PUSH:
            begin
                if (full)
                    status_c = stk_pkg::ST_FULL;
                else
                    push_ok = 1'b1;
            end
            stk_pkg::ACT_POP:
            begin
                if (empty)
                    status_c = stk_pkg::ST_EMPTY;
                else
                    pop_ok = 1'b1;
            end
            stk_pkg::ACT_INSERT:
            begin
                if (position > count_reg)
                    status_c = stk_pkg::ST_BADPOS;
                else if (full)
                    status_c = stk_pkg::ST_FULL;
                else
                    ins_ok = 1'b1;
            end
            stk_pkg::ACT_READ:
            begin
                if (empty)
                    status_c = stk_pkg::ST_EMPTY;
                else if (position >= count_reg)
                    status_c = stk_pkg::ST_BADPOS;
                else
                    rd_ok = 1'b1;
            end
            default:
            begin
                status_c = stk_pkg::ST_DONE;
            end
        endcase
    end

    always_comb
    begin
        if (push_ok || ins_ok)
            cnt_after = count_reg + CW'(1);
        else if (pop_ok)
            cnt_after = count_reg - CW'(1);
        else
            cnt_after = count_reg;
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        stk_pkg::word_t above_w;
        stk_pkg::word_t below_w;

        always_comb
        begin
            sel[i] = stk_pkg::SEL_HOLD;
            if (in_acc)
            begin
                if (push_ok)
                begin
                    sel[i] = (i == 0) ? stk_pkg::SEL_LOAD : stk_pkg::SEL_ABOVE;
                end
                else if (pop_ok)
                begin
                    sel[i] = (i == DEPTH - 1) ? stk_pkg::SEL_HOLD : stk_pkg::SEL_BELOW;
                end
                else if (ins_ok)
                begin
                    if (CW'(i) < position)
                        sel[i] = stk_pkg::SEL_HOLD;
                    else if (CW'(i) == position)
                        sel[i] = stk_pkg::SEL_LOAD;
                    else
                        sel[i] = stk_pkg::SEL_ABOVE;
                end
            end
        end

        if (i == 0)
        begin : g_first
            assign above_w = value;
        end
        else
        begin : g_mid
            assign above_w = word_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign below_w = '0;
        end
        else
        begin : g_inner
            assign below_w = word_q[i+1];
        end

        stk_cell u_cell (
            .clk       (clk),
            .sel       (sel[i]),
            .value     (value),
            .above     (above_w),
            .below     (below_w),
            .word      (word_q[i]),
            .word_next (word_d[i])
        );
    end

    always_comb
    begin
        if (act == stk_pkg::ACT_READ)
            rd_word = rd_ok ? word_q[position[IW-1:0]] : '0;
        else
            rd_word = (cnt_after == '0) ? '0 : word_d[0];
    end

    assign count_next     = in_acc ? cnt_after : count_reg;
    assign out_valid_next = in_acc ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            status_reg  <= status_c;
            cnt_out_reg <= cnt_after;
            rd_reg      <= rd_word;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign count      = cnt_out_reg;
    assign read_value = rd_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("stack count above depth");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && act == stk_pkg::ACT_PUSH && !full)
        |=> (out_valid && count_reg == $past(count_reg) + CW'(1)))
        else $error("push did not grow the stack by one");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && act == stk_pkg::ACT_POP && !empty)
        |=> (out_valid && count_reg == $past(count_reg) - CW'(1)))
        else $error("pop did not shrink the stack by one");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status_reg == stk_pkg::ST_EMPTY) |-> (cnt_out_reg == '0))
        else $error("empty status with entries held");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status_reg == stk_pkg::ST_FULL) |-> (cnt_out_reg == CW'(DEPTH)))
        else $error("full status on a stack that is not full");
`endif

endmodule

// ----- sim/stack_with_positional_insert_tb.sv -----
// Self-checking testbench for stack_with_positional_insert: directed and random requests
// with random stalls on both channels, each result beat checked against a stack predictor.
// Depends on stk_pkg and the design sources of stack_with_positional_insert.
module stack_with_positional_insert_tb;

    localparam int DEPTH = 16;
    localparam int POS_W = $clog2(DEPTH + 1);

    typedef struct {
        stk_pkg::status_t  status;
        logic [POS_W-1:0]  count;
        stk_pkg::word_t    read_value;
    } stack_reply_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        action;
    logic signed [31:0] value;
    logic [POS_W-1:0]  position;
    logic              out_valid;
    logic              out_stall;
    logic [1:0]        status;
    logic [POS_W-1:0]  count;
    logic signed [31:0] read_value;

    stk_pkg::word_t shadow_words [DEPTH];
    int            shadow_fill;
    stack_reply_t  replies_due [$];
    int            mismatches;
    bit            tx_idle_en;
    bit            rx_idle_en;
    int            rx_hold_cycles;

    stack_with_positional_insert #(
        .DEPTH(DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .value(value),
        .position(position),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .count(count),
        .read_value(read_value)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic stack_reply_t apply_stack_op(stk_pkg::action_t act,
                                                    stk_pkg::word_t val,
                                                    logic [POS_W-1:0] pos);
        stack_reply_t reply;
        bit           is_read;
        int           slot;
        reply.status = stk_pkg::ST_DONE;
        reply.read_value = '0;
        is_read = 1'b0;
        case (act)
            stk_pkg::ACT_PUSH:
            begin
                if (shadow_fill >= DEPTH)
                    reply.status = stk_pkg::ST_FULL;
                else
                begin
                    shadow_words[shadow_fill] = val;
                    shadow_fill++;
                end
            end
            stk_pkg::ACT_POP:
            begin
                if (shadow_fill == 0)
                    reply.status = stk_pkg::ST_EMPTY;
                else
                    shadow_fill--;
            end
            stk_pkg::ACT_INSERT:
            begin
                if (int'(pos) > shadow_fill)
                    reply.status = stk_pkg::ST_BADPOS;
                else if (shadow_fill >= DEPTH)
                    reply.status = stk_pkg::ST_FULL;
                else
                begin
                    slot = shadow_fill - int'(pos);
                    for (int i = shadow_fill; i > slot; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[slot] = val;
                    shadow_fill++;
                end
            end
            default:
            begin
                is_read = 1'b1;
                if (shadow_fill == 0)
                    reply.status = stk_pkg::ST_EMPTY;
                else if (int'(pos) >= shadow_fill)
                    reply.status = stk_pkg::ST_BADPOS;
                else
                    reply.read_value = shadow_words[shadow_fill - 1 - int'(pos)];
            end
        endcase
        if (!is_read && shadow_fill > 0)
            reply.read_value = shadow_words[shadow_fill - 1];
        reply.count = shadow_fill[POS_W-1:0];
        return reply;
    endfunction

    always @(posedge clk)
    begin
        stack_reply_t due;
        if (rst_n)
        begin
            if (out_valid === 1'b1 && out_stall == 1'b0)
            begin
                if (replies_due.size() == 0)
                begin
                    $error("result beat with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    due = replies_due.pop_front();
                    if (status !== due.status)
                    begin
                        $error("status: expected %0d, actual %0d", due.status, status);
                        mismatches++;
                    end
                    if (count !== due.count)
                    begin
                        $error("count: expected %0d, actual %0d", due.count, count);
                        mismatches++;
                    end
                    if (read_value !== due.read_value)
                    begin
                        $error("read_value: expected %0d, actual %0d",
                               due.read_value, read_value);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_stall === 1'b0)
                replies_due.push_back(apply_stack_op(stk_pkg::action_t'(action),
                                                     value, position));
        end
    end

    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
                out_stall <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_request(input stk_pkg::action_t act, input stk_pkg::word_t val,
                                input logic [POS_W-1:0] pos);
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        value <= val;
        position <= pos;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    function automatic stk_pkg::word_t pick_word();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return '0;
            3: return -32'sd1;
            default: return stk_pkg::word_t'($urandom);
        endcase
    endfunction

    task automatic random_requests(input int n, input int push_weight);
        stk_pkg::action_t act;
        int               pick;
        int               held;
        logic [POS_W-1:0] pos;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < push_weight)
                act = stk_pkg::ACT_PUSH;
            else if (pick < push_weight + 25)
                act = stk_pkg::ACT_INSERT;
            else if (pick < push_weight + 50)
                act = stk_pkg::ACT_READ;
            else
                act = stk_pkg::ACT_POP;
            held = shadow_fill;
            if ($urandom_range(0, 7) != 0 && held > 0)
                pos = POS_W'($urandom_range(0,
                             held - (act == stk_pkg::ACT_READ ? 1 : 0)));
            else
                pos = POS_W'($urandom_range(0, DEPTH));
            send_request(act, pick_word(), pos);
        end
    endtask

    task automatic test_empty_stack();
        send_request(stk_pkg::ACT_READ, 32'sd5, POS_W'(0));
        send_request(stk_pkg::ACT_POP, 32'sd5, POS_W'(0));
        send_request(stk_pkg::ACT_INSERT, 32'sd9, POS_W'(1));
        send_request(stk_pkg::ACT_INSERT, 32'sh7FFF_FFFF, POS_W'(0));
    endtask

    task automatic test_insert_depths();
        send_request(stk_pkg::ACT_PUSH, 32'sh8000_0000, POS_W'(0));
        send_request(stk_pkg::ACT_INSERT, -32'sd1, POS_W'(2));
        send_request(stk_pkg::ACT_INSERT, 32'sd0, POS_W'(1));
        send_request(stk_pkg::ACT_READ, 32'sd0, POS_W'(0));
        send_request(stk_pkg::ACT_READ, 32'sd0, POS_W'(3));
        send_request(stk_pkg::ACT_READ, 32'sd0, POS_W'(4));
        send_request(stk_pkg::ACT_INSERT, 32'sd1, POS_W'(5));
    endtask

    task automatic test_full_stack();
        for (int k = 0; k < 12; k++)
            send_request(stk_pkg::ACT_PUSH, pick_word(), POS_W'(0));
        send_request(stk_pkg::ACT_PUSH, 32'sd3, POS_W'(0));
        send_request(stk_pkg::ACT_INSERT, 32'sd4, POS_W'(DEPTH));
        send_request(stk_pkg::ACT_READ, 32'sd0, POS_W'(DEPTH - 1));
        send_request(stk_pkg::ACT_READ, 32'sd0, POS_W'(DEPTH));
    endtask

    task automatic test_output_backpressure();
        tx_idle_en = 1'b0;
        rx_hold_cycles = 40;
        random_requests(20, 20);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        random_requests(120, 40);
        random_requests(120, 5);
        random_requests(150, 20);
        wait_drained();
        random_requests(120, 40);
        random_requests(100, 10);
    endtask

    task automatic test_full_rate();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        random_requests(120, 35);
        random_requests(120, 15);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        action <= stk_pkg::ACT_PUSH;
        value <= '0;
        position <= '0;
        shadow_fill = 0;
        mismatches = 0;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        rx_hold_cycles = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_stack();
        test_insert_depths();
        test_full_stack();
        wait_drained();
        test_output_backpressure();
        test_random_traffic();
        test_full_rate();
        wait_drained();
        repeat (5) @(posedge clk);

        if (mismatches == 0 && replies_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
